FILE: rtl/kpc_pkg.sv
package kpc_pkg;

    localparam int NUM_KEYS_DEF = 16;
    localparam int CNT_W        = 8;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] SHORT_TICKS_RST      = 8'd1;
    localparam logic [CNT_W-1:0] LONG_TICKS_RST       = 8'd25;
    localparam logic [CNT_W-1:0] PRE_REPEAT_TICKS_RST = 8'd25;
    localparam logic [CNT_W-1:0] REPEAT_TICKS_RST     = 8'd25;

    localparam logic [1:0] REG_SHORT_TICKS      = 2'd0;
    localparam logic [1:0] REG_LONG_TICKS       = 2'd1;
    localparam logic [1:0] REG_PRE_REPEAT_TICKS = 2'd2;
    localparam logic [1:0] REG_REPEAT_TICKS     = 2'd3;

    typedef enum logic [1:0] {
        PH_RELEASED,
        PH_PUSHED,
        PH_BEFORE_REPEAT,
        PH_REPEATING
    } t_phase;

    typedef enum logic [1:0] {
        ACT_SHORT  = 2'd0,
        ACT_LONG   = 2'd1,
        ACT_REPEAT = 2'd2
    } t_action;

    typedef struct packed {
        logic [3:0] key_index;
        logic [7:0] report_code;
        logic       pressed;
    } t_in_item;

    typedef struct packed {
        logic [3:0] event_key_index;
        logic [7:0] event_report_code;
        logic [1:0] action;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] short_ticks;
        logic [CNT_W-1:0] long_ticks;
        logic [CNT_W-1:0] pre_repeat_ticks;
        logic [CNT_W-1:0] repeat_ticks;
    } t_kpc_cfg;

    typedef struct packed {
        t_phase           phase;
        logic [CNT_W-1:0] count;
    } t_key_state;

    localparam t_key_state KEY_STATE_RST = '{phase: PH_RELEASED, count: '0};

    typedef struct packed {
        t_key_state nxt;
        logic       fire;
        t_action    act;
    } t_step_res;

    function automatic t_step_res kpc_step(t_key_state cur, logic held, t_kpc_cfg cfg);
        t_step_res        res;
        logic [CNT_W-1:0] cnt_inc;
        res.nxt  = cur;
        res.fire = 1'b0;
        res.act  = ACT_SHORT;
        cnt_inc  = (cur.count != CNT_MAX) ? cur.count + 1'b1 : cur.count;
        if (held) begin
            res.nxt.count = cnt_inc;
            unique case (cur.phase)
                PH_RELEASED: begin
                    res.nxt.phase = PH_PUSHED;
                    res.nxt.count = '0;
                end
                PH_PUSHED: begin
                    if (cnt_inc >= cfg.long_ticks) begin
                        res.nxt.phase = PH_BEFORE_REPEAT;
                        res.nxt.count = '0;
                        res.fire      = 1'b1;
                        res.act       = ACT_LONG;
                    end
                end
                PH_BEFORE_REPEAT: begin
                    if (cnt_inc >= cfg.pre_repeat_ticks) begin
                        res.nxt.phase = PH_REPEATING;
                        res.nxt.count = '0;
                    end
                end
                default: begin
                    if (cnt_inc >= cfg.repeat_ticks) begin
                        res.nxt.count = '0;
                        res.fire      = 1'b1;
                        res.act       = ACT_REPEAT;
                    end
                end
            endcase
        end else begin
            unique case (cur.phase)
                PH_PUSHED: begin
                    if (cur.count >= cfg.long_ticks) begin
                        res.fire = 1'b1;
                        res.act  = ACT_LONG;
                    end else if (cur.count >= cfg.short_ticks) begin
                        res.fire = 1'b1;
                        res.act  = ACT_SHORT;
                    end
                end
                PH_REPEATING: begin
                    if (cur.count >= cfg.repeat_ticks) begin
                        res.fire = 1'b1;
                        res.act  = ACT_REPEAT;
                    end
                end
                default: begin
                    res.fire = 1'b0;
                end
            endcase
            res.nxt = KEY_STATE_RST;
        end
        return res;
    endfunction

endpackage

FILE: rtl/kpc_cfg_regs.sv
module kpc_cfg_regs
    import kpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_kpc_cfg          o_cfg
);

    t_kpc_cfg   r_cfg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ticks      <= SHORT_TICKS_RST;
            r_cfg.long_ticks       <= LONG_TICKS_RST;
            r_cfg.pre_repeat_ticks <= PRE_REPEAT_TICKS_RST;
            r_cfg.repeat_ticks     <= REPEAT_TICKS_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_SHORT_TICKS:      r_cfg.short_ticks      <= pwdata[CNT_W-1:0];
                REG_LONG_TICKS:       r_cfg.long_ticks       <= pwdata[CNT_W-1:0];
                REG_PRE_REPEAT_TICKS: r_cfg.pre_repeat_ticks <= pwdata[CNT_W-1:0];
                REG_REPEAT_TICKS:     r_cfg.repeat_ticks     <= pwdata[CNT_W-1:0];
                default:              r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_SHORT_TICKS:      prdata[CNT_W-1:0] = r_cfg.short_ticks;
            REG_LONG_TICKS:       prdata[CNT_W-1:0] = r_cfg.long_ticks;
            REG_PRE_REPEAT_TICKS: prdata[CNT_W-1:0] = r_cfg.pre_repeat_ticks;
            REG_REPEAT_TICKS:     prdata[CNT_W-1:0] = r_cfg.repeat_ticks;
            default:              prdata            = '0;
        endcase
    end

endmodule

FILE: rtl/kpc_state_mem.sv
module kpc_state_mem
    import kpc_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF,
    parameter int KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [KEY_AW-1:0] i_rd_addr,
    output t_key_state        o_rd_state,
    input  logic              i_wr_en,
    input  logic [KEY_AW-1:0] i_wr_addr,
    input  t_key_state        i_wr_state
);

    t_key_state            mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]   r_written;
    t_key_state            r_rd_data;
    logic [KEY_AW-1:0]     r_rd_addr;
    logic                  r_last_vld;
    logic [KEY_AW-1:0]     r_last_addr;
    t_key_state            r_last_state;

    // storage, read-before-write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_state;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // per-entry written flags and most recent write for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written  <= '0;
            r_last_vld <= 1'b0;
        end else if (i_wr_en) begin
            r_written[i_wr_addr] <= 1'b1;
            r_last_vld           <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_last_addr  <= i_wr_addr;
            r_last_state <= i_wr_state;
        end
    end

    always_comb begin
        if (r_last_vld && (r_last_addr == r_rd_addr)) begin
            o_rd_state = r_last_state;
        end else if (!r_written[r_rd_addr]) begin
            o_rd_state = KEY_STATE_RST;
        end else begin
            o_rd_state = r_rd_data;
        end
    end

endmodule

FILE: rtl/key_press_classifier.sv
// Short/long press and auto-repeat classifier for up to NUM_KEYS keys (at most 16, the
// range of key_index). Each input transfer is one periodic sample of one key; a sample
// for a slot at or beyond NUM_KEYS is dropped. Per-key phase and hold count sit in a
// small state memory that is read at the edge taking the sample and written back when
// the sample leaves the sample stage, with the latest write forwarded, so one sample is
// taken every cycle while the output register is not stalled. An event, if any, moves
// from the sample stage register into the output register, which holds it until its
// transfer completes; meanwhile the sample behind it waits and the input stalls.
// Thresholds are set through the APB port (short, long, pre-repeat, repeat at byte
// addresses 0, 4, 8, 12) and must only change while no sample is in flight.
module key_press_classifier
    import kpc_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    t_kpc_cfg          cfg;
    logic              in_xfer;
    logic [8:0]        in_idx_ext;
    logic              in_range;
    logic [KEY_AW-1:0] in_addr;
    logic [8:0]        s1_idx_ext;
    logic [KEY_AW-1:0] s1_addr;
    logic              s1_adv;
    t_key_state        s1_cur;
    t_step_res         s1_res;

    logic              r_s1_vld;
    logic              r_s1_inr;
    t_in_item          r_s1_item;
    logic              r_out_vld;
    t_out_item         r_out_item;

    kpc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_idx_ext = {5'b0, i_in_item.key_index};
    assign in_range   = (in_idx_ext < 9'(NUM_KEYS));
    assign in_addr    = in_idx_ext[KEY_AW-1:0];
    assign s1_idx_ext = {5'b0, r_s1_item.key_index};
    assign s1_addr    = s1_idx_ext[KEY_AW-1:0];

    assign s1_adv     = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    kpc_state_mem #(
        .NUM_KEYS (NUM_KEYS),
        .KEY_AW   (KEY_AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_xfer && in_range),
        .i_rd_addr  (in_addr),
        .o_rd_state (s1_cur),
        .i_wr_en    (r_s1_vld && r_s1_inr && s1_adv),
        .i_wr_addr  (s1_addr),
        .i_wr_state (s1_res.nxt)
    );

    assign s1_res = kpc_step(s1_cur, r_s1_item.pressed, cfg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= i_in_item;
            r_s1_inr  <= in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld && r_s1_inr && s1_res.fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_item.event_key_index   <= r_s1_item.key_index;
            r_out_item.event_report_code <= r_s1_item.report_code;
            r_out_item.action            <= s1_res.act;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

FILE: sim/key_press_classifier_test.sv
module key_press_classifier_test
    import kpc_pkg::*;
();

    class key_event_board;
        t_kpc_cfg   cfg;
        t_phase     phase_of [NUM_KEYS_DEF];
        logic [7:0] count_of [NUM_KEYS_DEF];
        t_out_item  pending_events [$];
        int         errors;

        function new();
            cfg = '{short_ticks: SHORT_TICKS_RST, long_ticks: LONG_TICKS_RST,
                    pre_repeat_ticks: PRE_REPEAT_TICKS_RST,
                    repeat_ticks: REPEAT_TICKS_RST};
            for (int k = 0; k < NUM_KEYS_DEF; k++) begin
                phase_of[k] = PH_RELEASED;
                count_of[k] = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        function void note_sample(t_in_item s);
            int         k;
            t_phase     ph;
            logic [7:0] cnt;
            logic       fire;
            t_action    act;
            t_out_item  ev;
            k = s.key_index;
            if (k >= NUM_KEYS_DEF) begin
                return;
            end
            ph   = phase_of[k];
            cnt  = count_of[k];
            fire = 1'b0;
            act  = ACT_SHORT;
            if (s.pressed) begin
                if (cnt != 8'hff) begin
                    cnt = cnt + 8'd1;
                end
                case (ph)
                    PH_RELEASED: begin
                        ph  = PH_PUSHED;
                        cnt = '0;
                    end
                    PH_PUSHED: begin
                        if (cnt >= cfg.long_ticks) begin
                            ph   = PH_BEFORE_REPEAT;
                            cnt  = '0;
                            fire = 1'b1;
                            act  = ACT_LONG;
                        end
                    end
                    PH_BEFORE_REPEAT: begin
                        if (cnt >= cfg.pre_repeat_ticks) begin
                            ph  = PH_REPEATING;
                            cnt = '0;
                        end
                    end
                    default: begin
                        if (cnt >= cfg.repeat_ticks) begin
                            cnt  = '0;
                            fire = 1'b1;
                            act  = ACT_REPEAT;
                        end
                    end
                endcase
            end else begin
                if (ph == PH_PUSHED) begin
                    if (cnt >= cfg.long_ticks) begin
                        fire = 1'b1;
                        act  = ACT_LONG;
                    end else if (cnt >= cfg.short_ticks) begin
                        fire = 1'b1;
                        act  = ACT_SHORT;
                    end
                end else if (ph == PH_REPEATING && cnt >= cfg.repeat_ticks) begin
                    fire = 1'b1;
                    act  = ACT_REPEAT;
                end
                ph  = PH_RELEASED;
                cnt = '0;
            end
            phase_of[k] = ph;
            count_of[k] = cnt;
            if (fire) begin
                ev.event_key_index   = s.key_index;
                ev.event_report_code = s.report_code;
                ev.action            = act;
                pending_events.push_back(ev);
            end
        endfunction

        function void check_event(t_out_item got);
            t_out_item exp_ev;
            if (pending_events.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected event: key %0d code %02h action %0d",
                             got.event_key_index, got.event_report_code, got.action);
                end
                return;
            end
            exp_ev = pending_events.pop_front();
            if (got.event_key_index != exp_ev.event_key_index ||
                got.event_report_code != exp_ev.event_report_code ||
                got.action != exp_ev.action) begin
                errors++;
                if (errors <= 10) begin
                    $display("expected key/code/action %0d/%02h/%0d, got %0d/%02h/%0d",
                             exp_ev.event_key_index, exp_ev.event_report_code,
                             exp_ev.action, got.event_key_index,
                             got.event_report_code, got.action);
                end
            end
        endfunction

        function void flush_leftovers();
            if (pending_events.size() != 0) begin
                $display("%0d expected events never arrived", pending_events.size());
                errors += pending_events.size();
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_item;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    key_event_board board = new();
    bit in_steady  = 1'b0;
    bit out_steady = 1'b0;
    bit hold_off_pending = 1'b0;

    key_press_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                board.check_event(o_out_item);
            end
            if (i_in_valid && o_in_ready) begin
                board.note_sample(i_in_item);
            end
        end
    end

    // event receiver
    initial begin
        int wait_cycles;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                i_out_ready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end
            wait_cycles = out_steady ? 0 : $urandom_range(0, 8);
            if (wait_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic apb_write(logic [1:0] sel, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic configure(logic [7:0] s, logic [7:0] l, logic [7:0] p, logic [7:0] r);
        apb_write(REG_SHORT_TICKS, s);
        apb_write(REG_LONG_TICKS, l);
        apb_write(REG_PRE_REPEAT_TICKS, p);
        apb_write(REG_REPEAT_TICKS, r);
        psel    <= 1'b0;
        penable <= 1'b0;
        board.cfg = '{short_ticks: s, long_ticks: l, pre_repeat_ticks: p, repeat_ticks: r};
    endtask

    task automatic send_sample(logic [3:0] key, logic [7:0] code, logic held);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{key_index: key, report_code: code, pressed: held};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic tap(logic [3:0] key, logic [7:0] code, logic held, int n);
        repeat (n) send_sample(key, code, held);
    endtask

    task automatic drain();
        int n;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        for (n = 0; n < 2000 && board.pending() != 0; n++) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_presses(int items, int focus_n, int hold_max, int short_max);
        logic [3:0] fkey [3];
        logic [7:0] fcode [3];
        int         left [3];
        int         f;
        for (f = 0; f < 3; f++) begin
            fkey[f]  = 4'($urandom_range(0, 15));
            fcode[f] = 8'($urandom);
            left[f]  = 0;
        end
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_sample(4'($urandom_range(0, 15)), 8'($urandom),
                            1'($urandom_range(0, 1)));
            end else begin
                f = $urandom_range(0, focus_n - 1);
                if (left[f] > 0) begin
                    left[f]--;
                    send_sample(fkey[f], fcode[f], 1'b1);
                end else begin
                    send_sample(fkey[f], fcode[f], 1'b0);
                    if ($urandom_range(0, 3) == 0) begin
                        fkey[f] = 4'($urandom_range(0, 15));
                    end
                    fcode[f] = 8'($urandom);
                    left[f]  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, short_max)
                                                          : $urandom_range(hold_max * 3 / 4,
                                                                           hold_max);
                end
            end
        end
    endtask

    task automatic press_phase(int s, int l, int p, int r, int items, int focus_n);
        int hold_max;
        configure(8'(s), 8'(l), 8'(p), 8'(r));
        hold_max = l + p + 3 * r + 4;
        if (hold_max > 300) begin
            hold_max = 300;
        end
        if (hold_max < 8) begin
            hold_max = 8;
        end
        in_steady  = ($urandom_range(0, 3) == 0);
        out_steady = ($urandom_range(0, 3) == 0);
        run_presses(items, focus_n, hold_max, s + 2);
        drain();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(8'd1, 8'd3, 8'd2, 8'd2);
        tap(4'd0, 8'h00, 1'b1, 1);
        tap(4'd0, 8'h00, 1'b0, 1);
        tap(4'd0, 8'hff, 1'b1, 2);
        tap(4'd0, 8'hff, 1'b0, 1);
        tap(4'd15, 8'ha5, 1'b1, 8);
        tap(4'd15, 8'ha5, 1'b0, 1);
        tap(4'd7, 8'h5a, 1'b1, 3);
        tap(4'd7, 8'h5a, 1'b0, 1);
        drain();

        // zero thresholds, then fill the block while the receiver holds off
        configure(8'd0, 8'd0, 8'd0, 8'd0);
        tap(4'd9, 8'h81, 1'b1, 1);
        tap(4'd9, 8'h81, 1'b0, 1);
        tap(4'd9, 8'h81, 1'b1, 4);
        tap(4'd9, 8'h81, 1'b0, 1);
        in_steady  = 1'b1;
        hold_off_pending = 1'b1;
        run_presses(130, 3, 8, 2);
        drain();

        press_phase(SHORT_TICKS_RST, LONG_TICKS_RST, PRE_REPEAT_TICKS_RST, REPEAT_TICKS_RST,
                    150, 2);
        repeat (3) begin
            press_phase($urandom_range(0, 6), $urandom_range(0, 8), $urandom_range(0, 8),
                        $urandom_range(0, 8), 120, 3);
        end
        press_phase(255, 255, 255, 255, 300, 1);

        board.flush_leftovers();
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
